// ----- rtl/dda_line_point_walker_assert.svh -----
// Assertion macros used by the walker controller
`ifndef DDA_LINE_POINT_WALKER_ASSERT_SVH
`define DDA_LINE_POINT_WALKER_ASSERT_SVH

// implication checked every cycle outside reset
`define DDA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dda check failed");

// implication checked in the cycle after the antecedent
`define DDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dda check failed");

`endif

// ----- rtl/dda_pkg.sv -----
package dda_pkg;
  localparam int COORD_BITS = 5;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS;       // acc value, bound keeps it below 2^ACC
  localparam int SLOPE_BITS = COORD_BITS + FRAC_BITS + 2;   // signed slope
  localparam int SQ_BITS    = 2 * COORD_BITS + 1;           // dx^2+dy^2
  localparam int RAD_BITS   = SQ_BITS + 2 * FRAC_BITS;      // radicand for d
  localparam int ROOT_BITS  = (RAD_BITS + 1) / 2;           // d in Q.F
  localparam int SQRT_ITERS = (RAD_BITS + 1) / 2;
  localparam int NUM_BITS   = COORD_BITS + 2 * FRAC_BITS;   // slope dividend
  localparam int STEP_BITS  = COORD_BITS + 2;               // point count
  localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);
  localparam int SQ_CNT_BITS  = $clog2(SQRT_ITERS + 1);

  // command from controller to datapath
  typedef struct packed {
    logic load;      // capture endpoints, set accumulators
    logic sqrt_step; // one root iteration
    logic div_init;  // start divisions
    logic div_step;  // one quotient bit of both divisions
    logic fin_slope; // apply signs, set count
    logic advance;   // step accumulators
  } dda_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic zero_len;
    logic last;
  } dda_stat_t;
endpackage

// ----- rtl/dda_ctrl.sv -----
module dda_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               out_fire,
  input  dda_pkg::dda_stat_t stat,
  output dda_pkg::dda_cmd_t  cmd,
  output logic               in_ready,
  output logic               out_valid
);
  import dda_pkg::*;
  `include "dda_line_point_walker_assert.svh"

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQRT = 5'b00010,
    S_DIV0 = 5'b00100,
    S_DIV  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [DIV_CNT_BITS-1:0] cnt, cnt_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);

  // sequencing
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_fire;
        cnt_next = '0;
        if (in_fire) state_next = S_SQRT;
      end
      S_SQRT: begin
        if (stat.zero_len) begin
          cmd.fin_slope = 1'b1;
          state_next    = S_EMIT;
        end else begin
          cmd.sqrt_step = 1'b1;
          cnt_next      = cnt + 1'b1;
          if (cnt == DIV_CNT_BITS'(SQRT_ITERS - 1)) state_next = S_DIV0;
        end
      end
      S_DIV0: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(NUM_BITS - 1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_fire) begin
          cmd.advance = 1'b1;
          if (stat.last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_DIV && cnt == DIV_CNT_BITS'(NUM_BITS - 1)) cmd.fin_slope = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `DDA_ASSERT_NEXT(a_last_idle, out_fire && stat.last, in_ready)
  `DDA_ASSERT_IMP(a_no_cmd_overlap, cmd.advance, !(cmd.load || cmd.sqrt_step || cmd.div_step))
  `DDA_ASSERT_NEXT(a_load_busy, in_fire, !in_ready)
endmodule

// ----- rtl/dda_datapath.sv -----
module dda_datapath (
  input  logic                         clk,
  input  logic [dda_pkg::COORD_BITS-1:0] start_x,
  input  logic [dda_pkg::COORD_BITS-1:0] start_y,
  input  logic [dda_pkg::COORD_BITS-1:0] end_x,
  input  logic [dda_pkg::COORD_BITS-1:0] end_y,
  input  dda_pkg::dda_cmd_t            cmd,
  output dda_pkg::dda_stat_t           stat,
  output logic [dda_pkg::COORD_BITS-1:0] point_x,
  output logic [dda_pkg::COORD_BITS-1:0] point_y,
  output logic                         last_point
);
  import dda_pkg::*;

  localparam int MAG_BITS = COORD_BITS + FRAC_BITS; // |end - start - 1/2|
  localparam logic [ACC_BITS:0] ACC_MAX = {1'b0, {ACC_BITS{1'b1}}};

  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [SQ_BITS-1:0]    sq;
  logic [RAD_BITS-1:0]   rem;       // root remainder (full radicand)
  logic [ROOT_BITS-1:0]  root;
  logic [NUM_BITS-1:0]   qx, qy;    // dividends shifting into quotients
  logic [ROOT_BITS:0]    rx, ry;    // partial remainders
  logic                  negx, negy;
  logic [ACC_BITS:0]     acc_x, acc_y;
  logic signed [SLOPE_BITS-1:0] slope_x, slope_y;
  logic [STEP_BITS-1:0]  steps_left;
  logic [SQ_CNT_BITS-1:0] sq_i;

  // endpoint distances
  logic [COORD_BITS-1:0] dx, dy;
  assign dx = (start_x > end_x) ? start_x - end_x : end_x - start_x;
  assign dy = (start_y > end_y) ? start_y - end_y : end_y - start_y;

  // restoring root step, one result bit per cycle, MSB pair first
  logic [RAD_BITS+1:0] trial;
  logic [RAD_BITS-1:0] rem_hi;
  logic [1:0]          pair;
  logic [RAD_BITS+1:0] rem_sh;
  logic [5:0]          sh;
  assign sh     = 6'(2 * (SQRT_ITERS - 1 - int'(sq_i)));
  assign pair   = 2'(({sq, {2*FRAC_BITS{1'b0}}} >> sh));
  assign rem_sh = {rem, pair};
  assign trial  = {root, 2'b01};
  assign rem_hi = '0;

  // divider step for one slope
  function automatic logic [ROOT_BITS:0] div_rem(input logic [ROOT_BITS:0] r,
                                                 input logic b,
                                                 input logic [ROOT_BITS-1:0] d);
    logic [ROOT_BITS+1:0] t;
    t = {r, b};
    if (t >= {2'b00, d}) t = t - {2'b00, d};
    return t[ROOT_BITS:0];
  endfunction

  function automatic logic div_bit(input logic [ROOT_BITS:0] r, input logic b,
                                   input logic [ROOT_BITS-1:0] d);
    return ({r, b} >= {2'b00, d});
  endfunction

  function automatic logic [MAG_BITS-1:0] mag_of(input logic [COORD_BITS-1:0] s,
                                                 input logic [COORD_BITS-1:0] e);
    logic [MAG_BITS-1:0] f, t;
    f = {s, 1'b1, {FRAC_BITS-1{1'b0}}};
    t = {e, {FRAC_BITS{1'b0}}};
    return (t < f) ? f - t : t - f;
  endfunction

  // saturating accumulator add
  function automatic logic [ACC_BITS:0] adv(input logic [ACC_BITS:0] a,
                                            input logic signed [SLOPE_BITS-1:0] s);
    logic signed [SLOPE_BITS+1:0] v;
    v = $signed({3'b000, a}) + s;
    if (v < 0) return '0;
    if (v > $signed({3'b000, ACC_MAX})) return ACC_MAX;
    return v[ACC_BITS:0];
  endfunction

  // final quotient bits including the one being shifted in this cycle
  logic [NUM_BITS-1:0] qx_f, qy_f;
  assign qx_f = {qx[NUM_BITS-2:0], div_bit(rx, qx[NUM_BITS-1], root)};
  assign qy_f = {qy[NUM_BITS-2:0], div_bit(ry, qy[NUM_BITS-1], root)};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx <= start_x; sy <= start_y; ex <= end_x; ey <= end_y;
      sq <= SQ_BITS'(dx * dx) + SQ_BITS'(dy * dy);
      acc_x <= {1'b0, start_x, 1'b1, {FRAC_BITS-1{1'b0}}};
      acc_y <= {1'b0, start_y, 1'b1, {FRAC_BITS-1{1'b0}}};
      rem <= '0; root <= '0; sq_i <= '0;
    end
    if (cmd.sqrt_step) begin
      sq_i <= sq_i + 1'b1;
      if (rem_sh >= trial) begin
        rem  <= RAD_BITS'(rem_sh - trial);
        root <= {root[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem  <= RAD_BITS'(rem_sh) | rem_hi;
        root <= {root[ROOT_BITS-2:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      qx <= {mag_of(sx, ex), {FRAC_BITS{1'b0}}};
      qy <= {mag_of(sy, ey), {FRAC_BITS{1'b0}}};
      negx <= ({ex, {FRAC_BITS{1'b0}}} < {sx, 1'b1, {FRAC_BITS-1{1'b0}}});
      negy <= ({ey, {FRAC_BITS{1'b0}}} < {sy, 1'b1, {FRAC_BITS-1{1'b0}}});
      rx <= '0; ry <= '0;
    end
    if (cmd.div_step) begin
      rx <= div_rem(rx, qx[NUM_BITS-1], root);
      ry <= div_rem(ry, qy[NUM_BITS-1], root);
      qx <= {qx[NUM_BITS-2:0], div_bit(rx, qx[NUM_BITS-1], root)};
      qy <= {qy[NUM_BITS-2:0], div_bit(ry, qy[NUM_BITS-1], root)};
    end
    if (cmd.fin_slope) begin
      if (sq == '0) begin
        slope_x <= '0; slope_y <= '0;
        steps_left <= STEP_BITS'(1);
      end else begin
        slope_x <= negx ? -$signed(SLOPE_BITS'(qx_f)) : $signed(SLOPE_BITS'(qx_f));
        slope_y <= negy ? -$signed(SLOPE_BITS'(qy_f)) : $signed(SLOPE_BITS'(qy_f));
        steps_left <= STEP_BITS'(root >> FRAC_BITS) + 1'b1;
      end
    end
    if (cmd.advance) begin
      acc_x <= adv(acc_x, slope_x);
      acc_y <= adv(acc_y, slope_y);
      steps_left <= steps_left - 1'b1;
    end
  end

  assign stat.zero_len = (sq == '0);
  assign stat.last     = (steps_left == STEP_BITS'(1));
  assign point_x    = acc_x[FRAC_BITS +: COORD_BITS];
  assign point_y    = acc_y[FRAC_BITS +: COORD_BITS];
  assign last_point = stat.last;
endmodule

// ----- rtl/dda_line_point_walker.sv -----
// channel | dir | tdata fields (low bit first)           | tuser
// s_axis  | in  | start_x, start_y, end_x, end_y (20b->24) | -
// m_axis  | out | point_x, point_y (10b->16)              | -, tlast = last_point
// A line is accepted, then runs the root steps, a divide init and the divide steps
// (one quotient bit a cycle for both slopes), then gives one point per cycle while
// m_axis_tready is high. Equal endpoints skip root and divide and emit one point.
// The input is taken only when idle; output stall holds the current point.
// rst is synchronous, active high, and returns the block to idle.
module dda_line_point_walker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // start_x, start_y, end_x, end_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // point_x, point_y
  output logic        m_axis_tlast
);
  import dda_pkg::*;

  dda_cmd_t  cmd;
  dda_stat_t stat;
  logic [COORD_BITS-1:0] px, py;

  dda_ctrl u_ctrl (
    .clk, .rst,
    .in_fire  (s_axis_tvalid && s_axis_tready),
    .out_fire (m_axis_tvalid && m_axis_tready),
    .stat, .cmd,
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid)
  );

  dda_datapath u_dp (
    .clk,
    .start_x (s_axis_tdata[4:0]),
    .start_y (s_axis_tdata[9:5]),
    .end_x   (s_axis_tdata[14:10]),
    .end_y   (s_axis_tdata[19:15]),
    .cmd, .stat,
    .point_x (px),
    .point_y (py),
    .last_point(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, py, px};
endmodule
